// ===== rtl/core/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants and codes for the line rasterizer core.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned COORD_BITS_DEF = 9;
  localparam int unsigned COLOR_BITS     = 16;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_ADVANCE = 1'b1
  } lr_func_t;

  // Line setup handed from the setup logic to the stepping engine.
  typedef struct packed {
    logic steep;
    logic minor_neg;
  } lr_dir_t;

endpackage

// ===== rtl/core/lr_setup.sv =====
// ----------------------------------------------------------------------------
// lr_setup
// Combinational line setup: major axis, endpoint swap, step sign and the
// initial decision term.
// ----------------------------------------------------------------------------
module lr_setup #(
  parameter int unsigned CB = lr_pkg::COORD_BITS_DEF
) (
  input  logic [CB-1:0]        x0,
  input  logic [CB-1:0]        y0,
  input  logic [CB-1:0]        x1,
  input  logic [CB-1:0]        y1,
  output logic [CB-1:0]        first_x,
  output logic [CB-1:0]        first_y,
  output logic [CB-1:0]        major_end,
  output logic [CB-1:0]        major_delta,
  output logic [CB-1:0]        minor_delta,
  output lr_pkg::lr_dir_t      dir,
  output logic signed [CB+2:0] decision
);
  import lr_pkg::*;

  logic [CB-1:0] adx;
  logic [CB-1:0] ady;
  logic          steep;
  logic          swap;
  logic [CB-1:0] sx0, sy0, sx1, sy1;

  always_comb begin
    adx   = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ady   = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    // equal deltas go y-major
    steep = !(ady < adx);
    swap  = steep ? (y0 > y1) : (x0 > x1);
    sx0   = swap ? x1 : x0;
    sy0   = swap ? y1 : y0;
    sx1   = swap ? x0 : x1;
    sy1   = swap ? y0 : y1;

    first_x       = sx0;
    first_y       = sy0;
    major_end     = steep ? sy1 : sx1;
    major_delta   = steep ? ady : adx;
    minor_delta   = steep ? adx : ady;
    dir.steep     = steep;
    dir.minor_neg = steep ? (sx1 < sx0) : (sy1 < sy0);
    decision      = $signed({2'b00, minor_delta, 1'b0}) - $signed({3'b000, major_delta});
  end

endmodule

// ===== rtl/core/lr_engine.sv =====
// ----------------------------------------------------------------------------
// lr_engine
// Line state registers and one Bresenham step per accepted advance.
// ----------------------------------------------------------------------------
module lr_engine #(
  parameter int unsigned CB = lr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  lr_pkg::lr_func_t              func,
  input  logic [CB-1:0]                 start_x,
  input  logic [CB-1:0]                 start_y,
  input  logic [CB-1:0]                 end_x,
  input  logic [CB-1:0]                 end_y,
  input  logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          push,
  output logic [CB-1:0]                 emit_x,
  output logic [CB-1:0]                 emit_y,
  output logic [lr_pkg::COLOR_BITS-1:0] emit_color,
  output logic                          emit_last
);
  import lr_pkg::*;

  localparam int unsigned DW = CB + 3;

  logic [CB-1:0]         cur_x, cur_y, major_end, major_delta, minor_delta;
  logic signed [DW-1:0]  decision;
  lr_dir_t               dir;
  logic [COLOR_BITS-1:0] line_color;
  logic                  active;

  logic [CB-1:0]         ld_x, ld_y, ld_end, ld_major, ld_minor;
  lr_dir_t               ld_dir;
  logic signed [DW-1:0]  ld_decision;

  logic [CB-1:0]         major, minor, major_step, minor_step;
  logic                  last, dec_pos;
  logic signed [DW-1:0]  dec_adj;
  logic [CB-1:0]         cur_x_next, cur_y_next;
  logic signed [DW-1:0]  decision_next;

  lr_setup #(.CB(CB)) u_setup (
    .x0          (start_x),
    .y0          (start_y),
    .x1          (end_x),
    .y1          (end_y),
    .first_x     (ld_x),
    .first_y     (ld_y),
    .major_end   (ld_end),
    .major_delta (ld_major),
    .minor_delta (ld_minor),
    .dir         (ld_dir),
    .decision    (ld_decision)
  );

  always_comb begin
    major      = dir.steep ? cur_y : cur_x;
    minor      = dir.steep ? cur_x : cur_y;
    last       = (major == major_end);
    dec_pos    = !decision[DW-1] && (decision != '0);
    major_step = major + CB'(1);
    minor_step = dir.minor_neg ? (minor - CB'(1)) : (minor + CB'(1));
    if (!dec_pos) begin
      minor_step = minor;
    end
    dec_adj       = dec_pos ? (decision - $signed({2'b00, major_delta, 1'b0})) : decision;
    decision_next = dec_adj + $signed({2'b00, minor_delta, 1'b0});
    cur_x_next    = dir.steep ? minor_step : major_step;
    cur_y_next    = dir.steep ? major_step : minor_step;

    push       = accept && (func == FUNC_ADVANCE) && active;
    emit_x     = cur_x;
    emit_y     = cur_y;
    emit_color = line_color;
    emit_last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept && (func == FUNC_LOAD)) begin
      active <= 1'b1;
    end else if (push && last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_LOAD)) begin
      cur_x       <= ld_x;
      cur_y       <= ld_y;
      major_end   <= ld_end;
      major_delta <= ld_major;
      minor_delta <= ld_minor;
      dir         <= ld_dir;
      decision    <= ld_decision;
      line_color  <= pixel_color;
    end else if (push && !last) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
  end

`ifndef ASSERT_OFF
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (push && last) |=> !active)
    else $error("engine still active after final pixel");
  a_load_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_LOAD)) |=> active)
    else $error("load did not arm the engine");
  a_step_major: assert property (@(posedge clk) disable iff (rst)
    (push && !last) |=> ((dir.steep ? cur_y : cur_x) == $past(major_step)))
    else $error("major coordinate did not advance by one");
`endif

endmodule

// ===== rtl/core/lr_obuf.sv =====
// ----------------------------------------------------------------------------
// lr_obuf
// Two-entry output queue that decouples the engine from the result channel.
// ----------------------------------------------------------------------------
module lr_obuf #(
  parameter int unsigned WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import lr_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full output queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue count out of range");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule

// ===== rtl/core/line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line generator for all octants, one pixel per advance.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// --------+---------------------+------------------------------------------------
// in      | in_valid / in_ready | func, start_x, start_y, end_x, end_y, pixel_color
// out     | out_valid/out_ready | pixel_x, pixel_y, color_out, last_pixel
//
// One item per cycle while in_ready is high: a load or an advance updates the
// line registers in the cycle it is accepted; an emitted pixel passes through
// the output queue to out. The step loop (one add and compare on the decision
// term) sets the rate. Reset leaves the engine idle and the output queue empty.
// in_ready drops only while both output queue entries hold untaken pixels.
// ----------------------------------------------------------------------------
module line_rasterizer_core #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [COORD_BITS-1:0]         start_x,
  input  logic [COORD_BITS-1:0]         start_y,
  input  logic [COORD_BITS-1:0]         end_x,
  input  logic [COORD_BITS-1:0]         end_y,
  input  logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [lr_pkg::COLOR_BITS-1:0] color_out,
  output logic                          last_pixel
);
  import lr_pkg::*;

  localparam int unsigned RW = 2 * COORD_BITS + COLOR_BITS + 1;

  logic                  accept, push, full, emit_last;
  logic [COORD_BITS-1:0] emit_x, emit_y;
  logic [COLOR_BITS-1:0] emit_color;
  logic [RW-1:0]         out_data;
  lr_func_t              func_code;

  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;
  assign func_code = lr_func_t'(func);

  lr_engine #(.CB(COORD_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func_code),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pixel_color (pixel_color),
    .push        (push),
    .emit_x      (emit_x),
    .emit_y      (emit_y),
    .emit_color  (emit_color),
    .emit_last   (emit_last)
  );

  lr_obuf #(.WIDTH(RW)) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({emit_x, emit_y, emit_color, emit_last}),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign {pixel_x, pixel_y, color_out, last_pixel} = out_data;

endmodule
